// ===== rtl/core/acdc_pkg.sv =====
// ----------------------------------------------------------------------------
// acdc_pkg
// Shared widths, constants and types of the dual channel AC/DC separator.
// ----------------------------------------------------------------------------
package acdc_pkg;

    localparam int WINDOW   = 50;
    localparam int SAMPLE_W = 18;
    localparam int SUM_W    = 24;
    localparam int DC_W     = 14;
    localparam int AC_W     = 15;
    localparam int SHIFT    = 4;

    // Reciprocal of WINDOW scaled by 2**RECIP_K, rounded up; exact for sums below 2**24
    localparam int RECIP_K  = 30;
    localparam int RECIP_W  = 30;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'(1) << RECIP_K) + 64'(WINDOW) - 64'(1)) / 64'(WINDOW));

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;

    typedef struct packed {
        logic [SAMPLE_W-1:0] ir;
        logic [SAMPLE_W-1:0] red;
    } pair_t;

    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
    } pipe_ctrl_t;

endpackage

// ===== rtl/core/dual_channel_ac_dc_separator_top.sv =====
// ----------------------------------------------------------------------------
// dual_channel_ac_dc_separator_top
// Moving-average DC removal for a red/infrared optical sample pair.
//
// The s_ stream carries one red and one infrared 18-bit sample per transfer;
// the m_ stream returns one result per input: AC part and DC level of each
// channel, both scaled down by 16. The DC level is the mean of the last 50
// samples of the channel, the warm-up counting reset zeros as history.
// History lives in a chain of 50 cells that shift by one on each accepted
// input; the oldest cell leaves the running sum as the new sample enters.
// From transfer to result the data passes the running sum, the reciprocal
// multiply for division, then subtract and output register. Throughput is
// one transfer per cycle with m_tready high; a stage holds while the next
// is stalled. s_tready drops only when all stages hold data and the result
// waits on m_tready. Reset clears history, sums and all valid flags.
// ----------------------------------------------------------------------------
module dual_channel_ac_dc_separator_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [acdc_pkg::S_TDATA_W-1:0]   s_tdata,  // red_sample, ir_sample, zero pad
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [acdc_pkg::M_TDATA_W-1:0]   m_tdata   // red_ac, red_dc, ir_ac, ir_dc, zero pad
);

    acdc_pkg::pair_t      in_pair;
    acdc_pkg::pair_t      hist [acdc_pkg::WINDOW];
    acdc_pkg::pipe_ctrl_t ctrl;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic out_valid_reg, out_valid_next;
    logic rdy2, rdy3;

    logic signed [acdc_pkg::AC_W-1:0] red_ac, ir_ac;
    logic [acdc_pkg::DC_W-1:0]        red_dc, ir_dc;

    assign in_pair.red = s_tdata[acdc_pkg::SAMPLE_W-1:0];
    assign in_pair.ir  = s_tdata[2*acdc_pkg::SAMPLE_W-1:acdc_pkg::SAMPLE_W];

    always_comb begin
        rdy3     = !out_valid_reg || m_tready;
        rdy2     = !v2_reg || rdy3;
        s_tready = !v1_reg || rdy2;

        ctrl.load1 = s_tvalid && s_tready;
        ctrl.load2 = v1_reg && rdy2;
        ctrl.load3 = v2_reg && rdy3;

        v1_next        = ctrl.load1 || (v1_reg && !ctrl.load2);
        v2_next        = ctrl.load2 || (v2_reg && !ctrl.load3);
        out_valid_next = ctrl.load3 || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    for (genvar i = 0; i < acdc_pkg::WINDOW; i++) begin : g_cell
        if (i == 0) begin : g_head
            acdc_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .shift   (ctrl.load1),
                .d       (in_pair),
                .q       (hist[i])
            );
        end else begin : g_body
            acdc_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .shift   (ctrl.load1),
                .d       (hist[i-1]),
                .q       (hist[i])
            );
        end
    end

    acdc_chan u_red (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .sample  (in_pair.red),
        .oldest  (hist[acdc_pkg::WINDOW-1].red),
        .ac      (red_ac),
        .dc      (red_dc)
    );

    acdc_chan u_ir (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .sample  (in_pair.ir),
        .oldest  (hist[acdc_pkg::WINDOW-1].ir),
        .ac      (ir_ac),
        .dc      (ir_dc)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, ir_dc, ir_ac, red_dc, red_ac};

endmodule

// ===== rtl/core/acdc_cell.sv =====
// ----------------------------------------------------------------------------
// acdc_cell
// One history cell: holds a red/infrared sample pair, takes its neighbour's
// pair on every accepted transfer.
// ----------------------------------------------------------------------------
module acdc_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          shift,
    input  acdc_pkg::pair_t d,
    output acdc_pkg::pair_t q
);

    acdc_pkg::pair_t pair_reg;
    acdc_pkg::pair_t pair_next;

    always_comb begin
        pair_next = shift ? d : pair_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_reg <= '0;
        end else begin
            pair_reg <= pair_next;
        end
    end

    assign q = pair_reg;

endmodule

// ===== rtl/core/acdc_chan.sv =====
// ----------------------------------------------------------------------------
// acdc_chan
// Per-channel datapath: running sum, divide by the window via reciprocal
// multiply, then AC part and output scaling.
// ----------------------------------------------------------------------------
module acdc_chan (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  acdc_pkg::pipe_ctrl_t            ctrl,
    input  logic [acdc_pkg::SAMPLE_W-1:0]   sample,
    input  logic [acdc_pkg::SAMPLE_W-1:0]   oldest,
    output logic signed [acdc_pkg::AC_W-1:0] ac,
    output logic [acdc_pkg::DC_W-1:0]       dc
);

    logic [acdc_pkg::SUM_W-1:0]    sum_reg;
    logic [acdc_pkg::SUM_W-1:0]    sum_next;
    logic [acdc_pkg::SAMPLE_W-1:0] samp1_reg;
    logic [acdc_pkg::SAMPLE_W-1:0] samp2_reg;
    logic [acdc_pkg::SAMPLE_W-1:0] mean2_reg;
    logic [acdc_pkg::SAMPLE_W-1:0] mean2_next;
    logic [acdc_pkg::PROD_W-1:0]   prod;
    logic signed [acdc_pkg::SAMPLE_W:0] diff;
    logic signed [acdc_pkg::AC_W-1:0]   ac_reg;
    logic [acdc_pkg::DC_W-1:0]     dc_reg;

    always_comb begin
        sum_next = sum_reg - acdc_pkg::SUM_W'(oldest) + acdc_pkg::SUM_W'(sample);
        prod = acdc_pkg::PROD_W'(sum_reg) * acdc_pkg::PROD_W'(acdc_pkg::RECIP);
        mean2_next = prod[acdc_pkg::RECIP_K +: acdc_pkg::SAMPLE_W];
        diff = $signed({1'b0, samp2_reg}) - $signed({1'b0, mean2_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctrl.load1) begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load1) begin
            samp1_reg <= sample;
        end
        if (ctrl.load2) begin
            samp2_reg <= samp1_reg;
            mean2_reg <= mean2_next;
        end
        if (ctrl.load3) begin
            ac_reg <= diff[acdc_pkg::SAMPLE_W:acdc_pkg::SHIFT];
            dc_reg <= mean2_reg[acdc_pkg::SAMPLE_W-1:acdc_pkg::SHIFT];
        end
    end

    assign ac = ac_reg;
    assign dc = dc_reg;

endmodule

// ===== rtl/core/acdc_checker.sv =====
// ----------------------------------------------------------------------------
// acdc_checker
// Port-level checks of the AC/DC separator, bound to the top level.
// ----------------------------------------------------------------------------
module acdc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [acdc_pkg::M_TDATA_W-1:0] m_tdata
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a stalled result");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing three cycles after transfer");

endmodule

bind dual_channel_ac_dc_separator_top acdc_checker u_acdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
